FILE: rtl/cdrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CDR image message parser package
// Shared result item type, status and kind codes, and encoding literals.
// ----------------------------------------------------------------------------
package cdrp_pkg;

    // Result item kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes, best first
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_BAD_ENC   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_MISMATCH  = 3'd5;

    // Encoding candidate flags: bit 0 bgr8, bit 1 bgra8
    localparam logic [1:0] MATCH_BOTH = 2'b11;
    localparam logic [1:0] MATCH_BGRA = 2'b10;

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic               item_kind;
        logic [7:0]         pixel_byte;
        logic [2:0]         status_code;
        logic signed [31:0] stamp_seconds;
        logic [31:0]        stamp_nanoseconds;
        logic [31:0]        image_rows;
        logic [31:0]        image_columns;
        logic               pixel_format;
        logic [7:0]         endian_marker;
        logic [31:0]        row_bytes;
        logic               final_item;
    } t_item;

    // Characters of "bgr8"
    function automatic logic [7:0] bgr8_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h62;
            2'd1:    ch = 8'h67;
            2'd2:    ch = 8'h72;
            default: ch = 8'h38;
        endcase
        return ch;
    endfunction

    // Characters of "bgra8"; codes past the end give zero
    function automatic logic [7:0] bgra8_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h67;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h38;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cdrp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CDR image message parser state machine
// Walks the message one byte per request and forms up to two result items.
// ----------------------------------------------------------------------------
module cdrp_parser #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [7:0]           i_byte,
    input  wire                 i_last,
    output logic                o_slot0_valid,
    output cdrp_pkg::t_item     o_slot0,
    output logic                o_slot1_valid,
    output cdrp_pkg::t_item     o_slot1
);

    localparam logic [3:0] PH_HEADER     = 4'd0;
    localparam logic [3:0] PH_SEC        = 4'd1;
    localparam logic [3:0] PH_NSEC       = 4'd2;
    localparam logic [3:0] PH_FRAME_LEN  = 4'd3;
    localparam logic [3:0] PH_FRAME_BODY = 4'd4;
    localparam logic [3:0] PH_HEIGHT     = 4'd5;
    localparam logic [3:0] PH_WIDTH      = 4'd6;
    localparam logic [3:0] PH_ENC_LEN    = 4'd7;
    localparam logic [3:0] PH_ENC_BODY   = 4'd8;
    localparam logic [3:0] PH_ENDIAN     = 4'd9;
    localparam logic [3:0] PH_STRIDE     = 4'd10;
    localparam logic [3:0] PH_DATA_LEN   = 4'd11;
    localparam logic [3:0] PH_DATA_BODY  = 4'd12;
    localparam logic [3:0] PH_DONE       = 4'd13;

    localparam int LW = LENGTH_WIDTH;

    logic [1:0]    r_pos,      n_pos;
    logic [3:0]    r_phase,    n_phase;
    logic [31:0]   r_asm,      n_asm;
    logic [LW-1:0] r_left,     n_left;
    logic [31:0]   r_sec,      n_sec;
    logic [31:0]   r_nsec,     n_nsec;
    logic [31:0]   r_rows,     n_rows;
    logic [31:0]   r_cols,     n_cols;
    logic [31:0]   r_stride,   n_stride;
    logic [7:0]    r_endian,   n_endian;
    logic [1:0]    r_match,    n_match;
    logic [LW-1:0] r_enc_len,  n_enc_len;
    logic [LW-1:0] r_seen,     n_seen;
    logic [2:0]    r_err,      n_err;
    logic [63:0]   r_expected;

    logic            w_pix_emit;
    cdrp_pkg::t_item w_pix_item;
    cdrp_pkg::t_item w_stat_item;

    function automatic logic [1:0] enc_check(input logic [1:0] flags,
                                             input logic [LW-1:0] len);
        logic [1:0] f;
        f[0] = flags[0] && (len == LW'(5));
        f[1] = flags[1] && (len == LW'(6));
        return f;
    endfunction

    always_comb begin
        logic [1:0]    v_sh;
        logic [31:0]   v_word;
        logic [LW-1:0] v_len;
        logic [LW-1:0] v_dec;
        logic [LW-1:0] v_k;
        logic [1:0]    v_flags;
        logic [1:0]    v_chk;
        logic [2:0]    v_code;

        n_pos     = r_pos + 2'd1;
        n_phase   = r_phase;
        n_asm     = r_asm;
        n_left    = r_left;
        n_sec     = r_sec;
        n_nsec    = r_nsec;
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_stride  = r_stride;
        n_endian  = r_endian;
        n_match   = r_match;
        n_enc_len = r_enc_len;
        n_seen    = r_seen;
        n_err     = r_err;
        w_pix_emit = 1'b0;

        v_sh    = 2'd0 - r_left[1:0];
        v_word  = r_asm | (32'(i_byte) << {v_sh, 3'b000});
        v_len   = v_word[LW-1:0];
        v_dec   = r_left - LW'(1);
        v_k     = r_enc_len - r_left;
        v_flags = r_match;
        v_chk   = 2'b00;

        unique case (r_phase)
            PH_HEADER: begin
                n_left = v_dec;
                if (v_dec == '0) begin
                    n_phase = PH_SEC;
                    n_left  = LW'(4);
                    n_asm   = '0;
                end
            end
            PH_SEC, PH_NSEC, PH_FRAME_LEN, PH_HEIGHT,
            PH_WIDTH, PH_ENC_LEN, PH_STRIDE, PH_DATA_LEN: begin
                // skip alignment padding before the first byte of a word
                if (!(r_left >= LW'(4) && r_pos != 2'd0)) begin
                    n_asm  = v_word;
                    n_left = v_dec;
                    if (v_dec == '0) begin
                        n_asm  = '0;
                        n_left = LW'(4);
                        unique case (r_phase)
                            PH_SEC: begin
                                n_sec   = v_word;
                                n_phase = PH_NSEC;
                            end
                            PH_NSEC: begin
                                n_nsec  = v_word;
                                n_phase = PH_FRAME_LEN;
                            end
                            PH_FRAME_LEN: begin
                                if (v_len != '0) begin
                                    n_phase = PH_FRAME_BODY;
                                    n_left  = v_len;
                                end else begin
                                    n_phase = PH_HEIGHT;
                                end
                            end
                            PH_HEIGHT: begin
                                n_rows  = v_word;
                                n_phase = PH_WIDTH;
                            end
                            PH_WIDTH: begin
                                n_cols  = v_word;
                                n_phase = PH_ENC_LEN;
                            end
                            PH_ENC_LEN: begin
                                n_enc_len = v_len;
                                n_match   = cdrp_pkg::MATCH_BOTH;
                                if (v_len != '0) begin
                                    n_phase = PH_ENC_BODY;
                                    n_left  = v_len;
                                end else begin
                                    // empty string never matches
                                    n_match = 2'b00;
                                    if (r_err == cdrp_pkg::ST_OK) begin
                                        n_err = cdrp_pkg::ST_BAD_ENC;
                                    end
                                    n_phase = PH_ENDIAN;
                                    n_left  = LW'(1);
                                end
                            end
                            PH_STRIDE: begin
                                n_stride = v_word;
                                n_phase  = PH_DATA_LEN;
                            end
                            PH_DATA_LEN: begin
                                n_seen = '0;
                                if (v_len == '0) begin
                                    if (r_err == cdrp_pkg::ST_OK) begin
                                        n_err = cdrp_pkg::ST_EMPTY;
                                    end
                                    n_phase = PH_DONE;
                                    n_left  = '0;
                                end else begin
                                    if (64'(v_len) < r_expected &&
                                        r_err == cdrp_pkg::ST_OK) begin
                                        n_err = cdrp_pkg::ST_MISMATCH;
                                    end
                                    n_phase = PH_DATA_BODY;
                                    n_left  = v_len;
                                end
                            end
                            default: begin
                                n_phase = PH_DONE;
                                n_left  = '0;
                            end
                        endcase
                    end
                end
            end
            PH_FRAME_BODY: begin
                n_left = v_dec;
                if (v_dec == '0) begin
                    n_phase = PH_HEIGHT;
                    n_left  = LW'(4);
                    n_asm   = '0;
                end
            end
            PH_ENC_BODY: begin
                // the string's final byte is not compared
                if (r_left > LW'(1)) begin
                    if (!(v_k < LW'(4) && i_byte == cdrp_pkg::bgr8_char(v_k[1:0]))) begin
                        v_flags[0] = 1'b0;
                    end
                    if (!(v_k < LW'(5) && i_byte == cdrp_pkg::bgra8_char(v_k[2:0]))) begin
                        v_flags[1] = 1'b0;
                    end
                end
                n_match = v_flags;
                n_left  = v_dec;
                if (v_dec == '0) begin
                    v_chk   = enc_check(v_flags, r_enc_len);
                    n_match = v_chk;
                    if (v_chk == 2'b00 && r_err == cdrp_pkg::ST_OK) begin
                        n_err = cdrp_pkg::ST_BAD_ENC;
                    end
                    n_phase = PH_ENDIAN;
                    n_left  = LW'(1);
                    n_asm   = '0;
                end
            end
            PH_ENDIAN: begin
                n_endian = i_byte;
                n_phase  = PH_STRIDE;
                n_left   = LW'(4);
                n_asm    = '0;
            end
            PH_DATA_BODY: begin
                w_pix_emit = (r_err == cdrp_pkg::ST_OK) && (64'(r_seen) < r_expected);
                n_seen     = r_seen + LW'(1);
                n_left     = v_dec;
                if (v_dec == '0) begin
                    n_phase = PH_DONE;
                    n_asm   = '0;
                end
            end
            default: begin
            end
        endcase

        if (n_phase == PH_HEADER) begin
            v_code = cdrp_pkg::ST_TOO_SHORT;
        end else if (n_phase != PH_DONE) begin
            v_code = cdrp_pkg::ST_TRUNCATED;
        end else begin
            v_code = n_err;
        end

        w_pix_item            = '0;
        w_pix_item.item_kind  = cdrp_pkg::KIND_PIXEL;
        w_pix_item.pixel_byte = i_byte;

        w_stat_item                   = '0;
        w_stat_item.item_kind         = cdrp_pkg::KIND_STATUS;
        w_stat_item.status_code       = v_code;
        w_stat_item.stamp_seconds     = n_sec;
        w_stat_item.stamp_nanoseconds = n_nsec;
        w_stat_item.image_rows        = n_rows;
        w_stat_item.image_columns     = n_cols;
        w_stat_item.pixel_format      = (n_match == cdrp_pkg::MATCH_BGRA);
        w_stat_item.endian_marker     = n_endian;
        w_stat_item.row_bytes         = n_stride;
        w_stat_item.final_item        = 1'b1;

        // end of message: start over for the next one
        if (i_last) begin
            n_pos     = '0;
            n_phase   = PH_HEADER;
            n_asm     = '0;
            n_left    = LW'(4);
            n_sec     = '0;
            n_nsec    = '0;
            n_rows    = '0;
            n_cols    = '0;
            n_stride  = '0;
            n_endian  = '0;
            n_match   = cdrp_pkg::MATCH_BOTH;
            n_enc_len = '0;
            n_seen    = '0;
            n_err     = cdrp_pkg::ST_OK;
        end
    end

    // pixel item first, status item after it
    assign o_slot0_valid = i_accept && (w_pix_emit || i_last);
    assign o_slot0       = w_pix_emit ? w_pix_item : w_stat_item;
    assign o_slot1_valid = i_accept && w_pix_emit && i_last;
    assign o_slot1       = w_stat_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= PH_HEADER;
            r_asm     <= '0;
            r_left    <= LW'(4);
            r_sec     <= '0;
            r_nsec    <= '0;
            r_rows    <= '0;
            r_cols    <= '0;
            r_stride  <= '0;
            r_endian  <= '0;
            r_match   <= cdrp_pkg::MATCH_BOTH;
            r_enc_len <= '0;
            r_seen    <= '0;
            r_err     <= cdrp_pkg::ST_OK;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_asm     <= n_asm;
            r_left    <= n_left;
            r_sec     <= n_sec;
            r_nsec    <= n_nsec;
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_stride  <= n_stride;
            r_endian  <= n_endian;
            r_match   <= n_match;
            r_enc_len <= n_enc_len;
            r_seen    <= n_seen;
            r_err     <= n_err;
        end
    end

    // rows*stride; the data length word is at least four requests behind stride
    always_ff @(posedge i_clk) begin
        r_expected <= 64'(r_rows) * 64'(r_stride);
    end

`ifndef SYNTHESIS
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_phase == PH_HEADER && r_err == cdrp_pkg::ST_OK))
        else $error("parser did not restart after end of message");

    a_pixel_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_slot0_valid && o_slot0.item_kind == cdrp_pkg::KIND_PIXEL) |->
        (r_phase == PH_DATA_BODY && r_err == cdrp_pkg::ST_OK))
        else $error("pixel item outside clean data body");
`endif

endmodule
`default_nettype wire

FILE: rtl/cdrp_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CDR image message parser result queue
// Small queue that takes up to two result items per cycle and drains one while the reader is ready.
// ----------------------------------------------------------------------------
module cdrp_out_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push0,
    input  wire cdrp_pkg::t_item i_data0,
    input  wire                 i_push1,
    input  wire cdrp_pkg::t_item i_data1,
    output logic                o_room,
    output logic                o_valid,
    output cdrp_pkg::t_item     o_data,
    input  wire                 i_ready
);

    localparam int DEPTH = cdrp_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cdrp_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    // room for a pixel and a status item together
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push0) + PW'(i_push1);
        n_rd_ptr = r_rd_ptr + PW'(w_pop);
        n_count  = r_count + CW'(i_push0) + CW'(i_push1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[PW'(r_wr_ptr + PW'(1))] <= i_data1;
        end
    end

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push0 |-> (r_count <= CW'(DEPTH - 2)))
        else $error("result queue overflow");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second slot pushed without first");
`endif

endmodule
`default_nettype wire

FILE: rtl/cdr_image_message_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CDR image message parser core
// Parses a serialized image message byte stream into pixel bytes and a status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the message, one byte per request in tdata[7:0], with tlast
//   on the final byte. m_axis carries result items: tuser is the item kind
//   (0 pixel byte, 1 status), tlast marks the status item that closes a
//   message. Every message yields its accepted pixel bytes followed by
//   exactly one status item carrying the header fields and a status code.
//   Output: result items are written into the queue when the byte that
//   causes them is accepted, and m_axis offers them from the queue head.
//   Throughput: one byte per cycle while s_axis_tready is high. The final
//   byte of a message may yield a pixel and the status, queued together.
//   Stalls: results collect in a four-entry queue; s_axis_tready stays high
//   while at least two entries are free, so the input keeps flowing through
//   short output stalls and holds once fewer than two entries are free.
//   Reset: i_rst_n low on a rising edge clears the parser to the header
//   phase and empties the queue; no clearing pass is needed.
//   On a truncated message, pixel bytes already sent must be dropped by the
//   receiver when it sees the error status.
// ----------------------------------------------------------------------------
module cdr_image_message_parser_core #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] payload_byte
    input  wire          s_axis_tlast,   // end_of_message
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [7:0] pixel_byte, [10:8] status_code, [42:11] stamp_seconds,
    // [74:43] stamp_nanoseconds, [106:75] image_rows, [138:107] image_columns,
    // [139] pixel_format, [147:140] endian_marker, [179:148] row_bytes,
    // [183:180] zero
    output logic [183:0] m_axis_tdata,
    output logic         m_axis_tuser,   // item_kind
    output logic         m_axis_tlast    // final_item
);

    logic            w_accept;
    logic            w_slot0_valid;
    logic            w_slot1_valid;
    cdrp_pkg::t_item w_slot0;
    cdrp_pkg::t_item w_slot1;
    cdrp_pkg::t_item w_head;
    logic            w_room;

    // hold the input once the queue lacks room for two items
    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    cdrp_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_slot0_valid (w_slot0_valid),
        .o_slot0       (w_slot0),
        .o_slot1_valid (w_slot1_valid),
        .o_slot1       (w_slot1)
    );

    cdrp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_slot0_valid),
        .i_data0 (w_slot0),
        .i_push1 (w_slot1_valid),
        .i_data1 (w_slot1),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .o_data  (w_head),
        .i_ready (m_axis_tready)
    );

    // pack the head item, pixel byte in the lowest bits
    assign m_axis_tdata = {4'b0000,
                           w_head.row_bytes,
                           w_head.endian_marker,
                           w_head.pixel_format,
                           w_head.image_columns,
                           w_head.image_rows,
                           w_head.stamp_nanoseconds,
                           w_head.stamp_seconds,
                           w_head.status_code,
                           w_head.pixel_byte};
    assign m_axis_tuser = w_head.item_kind;
    assign m_axis_tlast = w_head.final_item;

endmodule
`default_nettype wire
